FILE: src/rem_pkg.sv
package rem_pkg;

    localparam int LEVEL_W   = 16;
    localparam int MAG_W     = 14;
    localparam int DIV_STEPS = 16;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE   = 16'd32768;
    localparam logic [LEVEL_W-1:0] TH_RESET    = 16'd1638;
    localparam logic [MAG_W-1:0]   NOMINAL_MAX = 14'd10000;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_TICK  = 1'b1
    } rem_op_t;

    typedef enum logic {
        CFG_MASK   = 1'b0,
        CFG_THRESH = 1'b1
    } rem_cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_CH,
        S_SLOT,
        S_UPD,
        S_MUL,
        S_DIVS,
        S_DIV,
        S_ACC,
        S_EVAL,
        S_SEND,
        S_NEXT,
        S_FLUSH
    } rem_state_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] start_lvl;
        logic [LEVEL_W-1:0] end_lvl;
        logic [15:0]        remaining;
        logic [15:0]        total;
    } rem_entry_t;

    typedef struct packed {
        logic load_in;
        logic slot_clr;
        logic slot_inc;
        logic ch_clr;
        logic ch_inc;
        logic mem_rd;
        logic alloc;
        logic upd;
        logic mul;
        logic div_start;
        logic sum_clr;
        logic acc;
        logic eval;
        logic last_upd;
        logic pend_load;
        logic pend_clr;
        logic out_push;
        logic out_last;
    } rem_cmd_t;

    typedef struct packed {
        logic in_ch_ok;
        logic in_active;
        logic cur_active;
        logic slot_last;
        logic ch_last;
        logic ch_present;
        logic div_busy;
        logic send;
        logic pend_valid;
        logic out_free;
    } rem_stat_t;

    function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] v);
        return (v > LEVEL_ONE) ? LEVEL_ONE : v;
    endfunction

endpackage

FILE: src/rem_div.sv
module rem_div
    import rem_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [15:0] den,
    output logic        busy,
    output logic [15:0] quot
);

    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic [15:0] part_reg;
    logic [15:0] quo_reg;

    logic [16:0] trial;
    logic [16:0] diff;
    logic        ge;

    assign trial = {part_reg, quo_reg[15]};
    assign diff  = trial - {1'b0, den};
    assign ge    = (trial >= {1'b0, den});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= 5'(DIV_STEPS);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // quotient fits 16 bits, so the upper half starts below den
    always_ff @(posedge aclk) begin
        if (start) begin
            part_reg <= num[31:16];
            quo_reg  <= num[15:0];
        end else if (busy_reg) begin
            part_reg <= ge ? diff[15:0] : trial[15:0];
            quo_reg  <= {quo_reg[14:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quot = quo_reg;

endmodule

FILE: src/rem_dpath.sv
module rem_dpath
    import rem_pkg::*;
#(
    parameter int NCH   = 4,
    parameter int SLOTS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  rem_cfg_idx_t       cfg_idx,
    input  logic [15:0]        cfg_data,
    input  logic [1:0]         in_channel,
    input  logic [LEVEL_W-1:0] in_start,
    input  logic [LEVEL_W-1:0] in_end,
    input  logic               in_end_same,
    input  logic [15:0]        in_dur,
    input  rem_cmd_t           cmd,
    output rem_stat_t          stat,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         out_channel,
    output logic [MAG_W-1:0]   out_mag,
    output logic               out_last
);

    localparam int CH_W   = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ADDR_W = CH_W + SLOT_W;
    localparam int MEM_D  = 1 << ADDR_W;

    logic [3:0]         mask_reg;
    logic [LEVEL_W-1:0] thresh_reg;

    logic [1:0]         in_ch_reg;
    logic [LEVEL_W-1:0] lo_reg;
    logic [LEVEL_W-1:0] hi_reg;
    logic [15:0]        dur_reg;

    logic [SLOT_W-1:0]  slot_reg;
    logic [CH_W-1:0]    ch_reg;
    logic [SLOTS-1:0]   active_reg [NCH];

    rem_entry_t         mem [MEM_D];
    rem_entry_t         rd_reg;
    rem_entry_t         wr_data;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic               mem_we;

    logic               ge_reg;
    logic [LEVEL_W-1:0] diff_reg;
    logic [LEVEL_W-1:0] endl_reg;
    logic [15:0]        remd_reg;
    logic [15:0]        tot_reg;
    logic [31:0]        prod_reg;

    logic [LEVEL_W-1:0] sum_reg;
    logic [LEVEL_W-1:0] last_reg [NCH];
    logic               send_reg;
    logic [MAG_W-1:0]   mag_reg;

    logic               pend_valid_reg;
    logic [1:0]         pend_ch_reg;
    logic [MAG_W-1:0]   pend_mag_reg;

    logic               out_valid_reg;
    logic [1:0]         out_ch_reg;
    logic [MAG_W-1:0]   out_mag_reg;
    logic               out_last_reg;

    logic [CH_W-1:0]    in_ch_idx;
    logic [15:0]        rem_dec;
    logic               div_busy;
    logic [15:0]        quot;
    logic [16:0]        level;
    logic [16:0]        sum_add;
    logic [LEVEL_W-1:0] keep;
    logic [16:0]        keep_hi;
    logic [16:0]        sum_hi;
    logic               send_c;
    logic [29:0]        mag_prod;
    logic [NCH-1:0]     present;

    assign in_ch_idx = in_ch_reg[CH_W-1:0];
    assign present   = mask_reg[NCH-1:0];

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg   <= '0;
            thresh_reg <= TH_RESET;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                CFG_MASK:   mask_reg   <= cfg_data[3:0];
                CFG_THRESH: thresh_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // start command fields
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_ch_reg <= in_channel;
            lo_reg    <= clamp_level(in_start);
            hi_reg    <= in_end_same ? clamp_level(in_start) : clamp_level(in_end);
            dur_reg   <= (in_dur == 16'd0) ? 16'd1 : in_dur;
        end
    end

    // slot and channel counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
            ch_reg   <= '0;
        end else begin
            if (cmd.slot_clr) begin
                slot_reg <= '0;
            end else if (cmd.slot_inc) begin
                slot_reg <= slot_reg + SLOT_W'(1);
            end
            if (cmd.ch_clr) begin
                ch_reg <= '0;
            end else if (cmd.ch_inc) begin
                ch_reg <= ch_reg + CH_W'(1);
            end
        end
    end

    assign rem_dec = (rd_reg.remaining != 16'd0) ? rd_reg.remaining - 16'd1 : 16'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NCH; i++) begin
                active_reg[i] <= '0;
            end
        end else if (cmd.alloc) begin
            active_reg[in_ch_idx][slot_reg] <= 1'b1;
        end else if (cmd.upd && rem_dec == 16'd0) begin
            active_reg[ch_reg][slot_reg] <= 1'b0;
        end
    end

    // slot memory
    assign rd_addr = {ch_reg, slot_reg};
    assign mem_we  = cmd.alloc | cmd.upd;

    always_comb begin
        if (cmd.alloc) begin
            wr_addr           = {in_ch_idx, slot_reg};
            wr_data.start_lvl = lo_reg;
            wr_data.end_lvl   = hi_reg;
            wr_data.remaining = dur_reg;
            wr_data.total     = dur_reg;
        end else begin
            wr_addr           = rd_addr;
            wr_data           = rd_reg;
            wr_data.remaining = rem_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_rd) begin
            rd_reg <= mem[rd_addr];
        end
    end

    // ramp level
    always_ff @(posedge aclk) begin
        if (cmd.upd) begin
            ge_reg   <= (rd_reg.start_lvl >= rd_reg.end_lvl);
            diff_reg <= (rd_reg.start_lvl >= rd_reg.end_lvl) ?
                        rd_reg.start_lvl - rd_reg.end_lvl :
                        rd_reg.end_lvl - rd_reg.start_lvl;
            endl_reg <= rd_reg.end_lvl;
            remd_reg <= rem_dec;
            tot_reg  <= rd_reg.total;
        end
        if (cmd.mul) begin
            prod_reg <= diff_reg * remd_reg;
        end
    end

    rem_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (prod_reg),
        .den     (tot_reg),
        .busy    (div_busy),
        .quot    (quot)
    );

    assign level   = ge_reg ? {1'b0, endl_reg} + {1'b0, quot}
                            : {1'b0, endl_reg} - {1'b0, quot};
    assign sum_add = {1'b0, sum_reg} + level;

    always_ff @(posedge aclk) begin
        if (cmd.sum_clr) begin
            sum_reg <= '0;
        end else if (cmd.acc) begin
            sum_reg <= (sum_add > {1'b0, LEVEL_ONE}) ? LEVEL_ONE : sum_add[15:0];
        end
    end

    // change detection
    assign keep     = last_reg[ch_reg];
    assign keep_hi  = {1'b0, keep} + {1'b0, thresh_reg};
    assign sum_hi   = {1'b0, sum_reg} + {1'b0, thresh_reg};
    assign send_c   = ({1'b0, sum_reg} > keep_hi) || (sum_hi < {1'b0, keep}) ||
                      (keep != '0 && sum_reg == '0) ||
                      (keep != LEVEL_ONE && sum_reg == LEVEL_ONE);
    assign mag_prod = sum_reg * NOMINAL_MAX;

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            send_reg <= send_c;
            mag_reg  <= mag_prod[28:15];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NCH; i++) begin
                last_reg[i] <= '0;
            end
        end else if (cmd.last_upd) begin
            last_reg[ch_reg] <= sum_reg;
        end
    end

    // one result held back so the final one of a tick can carry tlast
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (cmd.pend_load) begin
            pend_valid_reg <= 1'b1;
        end else if (cmd.pend_clr) begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pend_load) begin
            pend_ch_reg  <= 2'(ch_reg);
            pend_mag_reg <= mag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_push) begin
            out_valid_reg <= 1'b1;
        end else if (out_valid_reg && out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_push) begin
            out_ch_reg   <= pend_ch_reg;
            out_mag_reg  <= pend_mag_reg;
            out_last_reg <= cmd.out_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_ch_reg;
    assign out_mag     = out_mag_reg;
    assign out_last    = out_last_reg;

    always_comb begin
        stat.in_ch_ok   = ({1'b0, in_ch_reg} < 3'(NCH));
        stat.in_active  = active_reg[in_ch_idx][slot_reg];
        stat.cur_active = active_reg[ch_reg][slot_reg];
        stat.slot_last  = (slot_reg == SLOT_W'(SLOTS - 1));
        stat.ch_last    = (ch_reg == CH_W'(NCH - 1));
        stat.ch_present = present[ch_reg];
        stat.div_busy   = div_busy;
        stat.send       = send_reg;
        stat.pend_valid = pend_valid_reg;
        stat.out_free   = !out_valid_reg;
    end

endmodule

FILE: src/rem_ctrl.sv
module rem_ctrl
    import rem_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    input  rem_op_t   in_op,
    output logic      in_ready,
    input  rem_stat_t stat,
    output rem_cmd_t  cmd
);

    rem_state_t state_reg;
    rem_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_in  = 1'b1;
                    cmd.slot_clr = 1'b1;
                    cmd.ch_clr   = 1'b1;
                    state_next   = (in_op == CMD_START) ? S_SCAN : S_CH;
                end
            end
            S_SCAN: begin
                if (!stat.in_ch_ok) begin
                    state_next = S_IDLE;
                end else if (!stat.in_active) begin
                    cmd.alloc  = 1'b1;
                    state_next = S_IDLE;
                end else if (stat.slot_last) begin
                    state_next = S_IDLE;
                end else begin
                    cmd.slot_inc = 1'b1;
                end
            end
            S_CH: begin
                if (stat.ch_present) begin
                    cmd.sum_clr  = 1'b1;
                    cmd.slot_clr = 1'b1;
                    state_next   = S_SLOT;
                end else begin
                    state_next = S_NEXT;
                end
            end
            S_SLOT: begin
                if (stat.cur_active) begin
                    cmd.mem_rd = 1'b1;
                    state_next = S_UPD;
                end else if (stat.slot_last) begin
                    state_next = S_EVAL;
                end else begin
                    cmd.slot_inc = 1'b1;
                end
            end
            S_UPD: begin
                cmd.upd    = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_DIVS;
            end
            S_DIVS: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV: begin
                if (!stat.div_busy) begin
                    state_next = S_ACC;
                end
            end
            S_ACC: begin
                cmd.acc = 1'b1;
                if (stat.slot_last) begin
                    state_next = S_EVAL;
                end else begin
                    cmd.slot_inc = 1'b1;
                    state_next   = S_SLOT;
                end
            end
            S_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = S_SEND;
            end
            S_SEND: begin
                if (!stat.send) begin
                    state_next = S_NEXT;
                end else if (!stat.pend_valid) begin
                    cmd.pend_load = 1'b1;
                    cmd.last_upd  = 1'b1;
                    state_next    = S_NEXT;
                end else if (stat.out_free) begin
                    cmd.out_push  = 1'b1;
                    cmd.pend_load = 1'b1;
                    cmd.last_upd  = 1'b1;
                    state_next    = S_NEXT;
                end
            end
            S_NEXT: begin
                if (stat.ch_last) begin
                    state_next = S_FLUSH;
                end else begin
                    cmd.ch_inc = 1'b1;
                    state_next = S_CH;
                end
            end
            S_FLUSH: begin
                if (!stat.pend_valid) begin
                    state_next = S_IDLE;
                end else if (stat.out_free) begin
                    cmd.out_push = 1'b1;
                    cmd.out_last = 1'b1;
                    cmd.pend_clr = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/rumble_envelope_mixer_top.sv
// channel  dir  transfer when          payload
// s_       in   s_tvalid & s_tready    tuser: cmd; tdata: effect fields
// m_       out  m_tvalid & m_tready    tdata: channel, magnitude; tlast: last of tick
// cfg_     in   cfg_valid & cfg_ready  cfg_index: register, cfg_data: value
//
// start: takes the first free slot of the channel, scanning from slot 0; dropped when all are full
// tick: per present channel, each active slot is read and updated, its ramp level found by
// the 16-step shared divider and summed; absent channels are skipped
// reset (aresetn low, synchronous) frees all slots and clears the last sent levels
// a held result stalls the tick when a further result of it, or the end of the tick,
// finds the output register still full

module rumble_envelope_mixer_top
    import rem_pkg::*;
#(
    parameter int CHANNELS = 4,
    parameter int SLOTS    = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] channel, [17:2] start_level, [33:18] end_level, [34] end_same,
    // [50:35] duration_frames, [55:51] zero
    input  logic [55:0] s_tdata,
    // [0] cmd
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] out_channel, [15:2] magnitude
    output logic [15:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int NCH = (CHANNELS < 4) ? CHANNELS : 4;

    rem_cmd_t         cmd;
    rem_stat_t        stat;
    rem_op_t          in_op;
    rem_cfg_idx_t     cfg_idx;
    logic [1:0]       out_channel;
    logic [MAG_W-1:0] out_mag;

    assign in_op     = rem_op_t'(s_tuser[0]);
    assign cfg_idx   = rem_cfg_idx_t'(cfg_index[0]);
    assign cfg_ready = 1'b1;

    rem_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_op    (in_op),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rem_dpath #(
        .NCH   (NCH),
        .SLOTS (SLOTS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_valid & cfg_ready),
        .cfg_idx     (cfg_idx),
        .cfg_data    (cfg_data),
        .in_channel  (s_tdata[1:0]),
        .in_start    (s_tdata[17:2]),
        .in_end      (s_tdata[33:18]),
        .in_end_same (s_tdata[34]),
        .in_dur      (s_tdata[50:35]),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_channel (out_channel),
        .out_mag     (out_mag),
        .out_last    (m_tlast)
    );

    assign m_tdata = {out_mag, out_channel};

endmodule

FILE: src/rem_checker.sv
module rem_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // held result stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_mag_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:2] <= 14'd10000)
        else $error("magnitude above nominal maximum");

    // a start transfer never produces a result
    a_start_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser[0] && !m_tvalid |=> !m_tvalid)
        else $error("result after start transfer");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("not idle after reset");

endmodule

bind rumble_envelope_mixer_top rem_checker u_rem_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
